[rtl/core/sbusfrd_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sbusfrd_pkg: shared types and constants
// Frame layout, register indexes and the unpack sequencer states.
// ---------------------------------------------------------------------------
package sbusfrd_pkg;

  localparam int unsigned ByteW   = 8;
  localparam int unsigned PosW    = 5;
  localparam int unsigned IdxW    = 4;
  localparam int unsigned ChanW   = 11;
  localparam int unsigned FlagW   = 4;
  localparam int unsigned AccW    = 18;
  localparam int unsigned CntW    = 5;
  localparam int unsigned CfgIdxW = 8;
  localparam int unsigned FrameLen = 25;

  localparam logic [PosW-1:0] FirstPayloadPos = 5'd1;
  localparam logic [PosW-1:0] FlagsPos        = 5'd23;
  localparam logic [PosW-1:0] EndPos          = 5'd24;

  localparam logic [IdxW-1:0] LastChan = 4'd15;

  localparam logic [CntW-1:0] ByteBits = 5'd8;
  localparam logic [CntW-1:0] ChanBits = 5'd11;

  localparam logic [CfgIdxW-1:0] RegStartByte = 8'd0;
  localparam logic [CfgIdxW-1:0] RegEndByte   = 8'd1;

  localparam logic [ByteW-1:0] StartByteRst = 8'h0F;
  localparam logic [ByteW-1:0] EndByteRst   = 8'h00;

  // write into the frame store
  typedef struct packed {
    logic             we;
    logic [PosW-1:0]  addr;
    logic [ByteW-1:0] data;
  } store_wr_t;

  typedef enum logic [1:0] {
    UnpIdle,
    UnpFetch,
    UnpMerge,
    UnpEmit
  } unp_state_e;

endpackage

[rtl/core/sbusfrd_unpack.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sbusfrd_unpack: frame store and channel unpacker
// Holds the 25-byte frame and, once a good frame closes, streams payload
// bytes through a bit accumulator, cutting one 11-bit channel at a time.
// ---------------------------------------------------------------------------
module sbusfrd_unpack (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  sbusfrd_pkg::store_wr_t          wr_i,
  input  logic                            start_i,
  input  logic [sbusfrd_pkg::FlagW-1:0]   flags_i,
  output logic                            busy_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [sbusfrd_pkg::IdxW-1:0]    channel_index_o,
  output logic [sbusfrd_pkg::ChanW-1:0]   channel_value_o,
  output logic                            digital_a_o,
  output logic                            digital_b_o,
  output logic                            frame_lost_o,
  output logic                            failsafe_o,
  output logic                            last_o
);

  logic [sbusfrd_pkg::ByteW-1:0] mem [sbusfrd_pkg::FrameLen];

  sbusfrd_pkg::unp_state_e state_q, state_d;

  logic [sbusfrd_pkg::PosW-1:0]  addr_q, addr_d;
  logic [sbusfrd_pkg::IdxW-1:0]  chan_q, chan_d;
  logic [sbusfrd_pkg::AccW-1:0]  acc_q, acc_d;
  logic [sbusfrd_pkg::CntW-1:0]  cnt_q, cnt_d;
  logic [sbusfrd_pkg::ByteW-1:0] rd_q;
  logic                          rd_en;
  logic                          out_free;
  logic                          out_load;
  logic                          out_valid_q, out_valid_d;
  logic [sbusfrd_pkg::IdxW-1:0]  idx_q;
  logic [sbusfrd_pkg::ChanW-1:0] val_q;
  logic [sbusfrd_pkg::FlagW-1:0] oflags_q;
  logic                          last_q;
  logic [sbusfrd_pkg::CntW-1:0]  cnt_merged;
  logic [sbusfrd_pkg::CntW-1:0]  cnt_left;

  assign out_free   = !out_valid_q || !out_stall_i;
  assign cnt_merged = cnt_q + sbusfrd_pkg::ByteBits;
  assign cnt_left   = cnt_q - sbusfrd_pkg::ChanBits;

  // frame store
  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      rd_q <= mem[addr_q];
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      sbusfrd_pkg::UnpIdle: begin
        if (start_i) begin
          state_d = sbusfrd_pkg::UnpFetch;
        end
      end
      sbusfrd_pkg::UnpFetch: begin
        state_d = sbusfrd_pkg::UnpMerge;
      end
      sbusfrd_pkg::UnpMerge: begin
        if (cnt_merged >= sbusfrd_pkg::ChanBits) begin
          state_d = sbusfrd_pkg::UnpEmit;
        end else begin
          state_d = sbusfrd_pkg::UnpFetch;
        end
      end
      sbusfrd_pkg::UnpEmit: begin
        if (out_free) begin
          if (chan_q == sbusfrd_pkg::LastChan) begin
            state_d = sbusfrd_pkg::UnpIdle;
          end else if (cnt_left >= sbusfrd_pkg::ChanBits) begin
            state_d = sbusfrd_pkg::UnpEmit;
          end else begin
            state_d = sbusfrd_pkg::UnpFetch;
          end
        end
      end
      default: begin
        state_d = sbusfrd_pkg::UnpIdle;
      end
    endcase
  end

  // datapath controls
  always_comb begin
    addr_d   = addr_q;
    chan_d   = chan_q;
    acc_d    = acc_q;
    cnt_d    = cnt_q;
    rd_en    = 1'b0;
    out_load = 1'b0;
    case (state_q)
      sbusfrd_pkg::UnpIdle: begin
        if (start_i) begin
          addr_d = sbusfrd_pkg::FirstPayloadPos;
          chan_d = '0;
          acc_d  = '0;
          cnt_d  = '0;
        end
      end
      sbusfrd_pkg::UnpFetch: begin
        rd_en  = 1'b1;
        addr_d = addr_q + 1'b1;
      end
      sbusfrd_pkg::UnpMerge: begin
        // new byte lands right above the bits still pending
        acc_d = acc_q | (sbusfrd_pkg::AccW'(rd_q) << cnt_q);
        cnt_d = cnt_merged;
      end
      sbusfrd_pkg::UnpEmit: begin
        if (out_free) begin
          out_load = 1'b1;
          acc_d    = acc_q >> sbusfrd_pkg::ChanW;
          cnt_d    = cnt_left;
          chan_d   = chan_q + 1'b1;
        end
      end
      default: begin
        rd_en = 1'b0;
      end
    endcase
  end

  always_comb begin
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= sbusfrd_pkg::UnpIdle;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    chan_q <= chan_d;
    acc_q  <= acc_d;
    cnt_q  <= cnt_d;
    if (out_load) begin
      idx_q    <= chan_q;
      val_q    <= acc_q[sbusfrd_pkg::ChanW-1:0];
      oflags_q <= flags_i;
      last_q   <= (chan_q == sbusfrd_pkg::LastChan);
    end
  end

  assign busy_o          = (state_q != sbusfrd_pkg::UnpIdle);
  assign out_valid_o     = out_valid_q;
  assign channel_index_o = idx_q;
  assign channel_value_o = val_q;
  assign digital_a_o     = oflags_q[0];
  assign digital_b_o     = oflags_q[1];
  assign frame_lost_o    = oflags_q[2];
  assign failsafe_o      = oflags_q[3];
  assign last_o          = last_q;

endmodule

[rtl/core/sbus_frame_receiver_decoder_top.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sbus_frame_receiver_decoder_top: 16-channel serial frame decoder
// Hunts for the start byte, collects a 25-byte frame and, when the end byte
// matches, emits one item per proportional channel with the frame flags.
// ---------------------------------------------------------------------------
//  channel | handshake              | payload
//  --------+------------------------+------------------------------------------
//  in      | in_valid_i / in_stall_o | rx_byte_i
//  out     | out_valid_o / out_stall_i | channel_index_o, channel_value_o,
//          |                        | digital_a_o, digital_b_o, frame_lost_o,
//          |                        | failsafe_o, last_o
//  cfg     | cfg_valid_i / cfg_ready_o | cfg_index_i, cfg_data_i
//
//  The input does not stall while the frame is being collected.
//  After the closing byte of a good frame the input stalls while the
//  unpacker reads 22 payload bytes from the frame store, each in a fetch
//  and merge state, and cuts 16 channels, one per emit state, longer if out stalls.
//  Reset clears the hunt state, byte position, registers and output valid;
//  the frame store is not cleared.
// ---------------------------------------------------------------------------
module sbus_frame_receiver_decoder_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_stall_o,
  input  logic [sbusfrd_pkg::ByteW-1:0]     rx_byte_i,
  output logic                              out_valid_o,
  input  logic                              out_stall_i,
  output logic [sbusfrd_pkg::IdxW-1:0]      channel_index_o,
  output logic [sbusfrd_pkg::ChanW-1:0]     channel_value_o,
  output logic                              digital_a_o,
  output logic                              digital_b_o,
  output logic                              frame_lost_o,
  output logic                              failsafe_o,
  output logic                              last_o,
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [sbusfrd_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [sbusfrd_pkg::ByteW-1:0]     cfg_data_i
);

  logic [sbusfrd_pkg::ByteW-1:0] start_byte_q, start_byte_d;
  logic [sbusfrd_pkg::ByteW-1:0] end_byte_q, end_byte_d;
  logic                          in_frame_q, in_frame_d;
  logic [sbusfrd_pkg::PosW-1:0]  pos_q, pos_d;
  logic [sbusfrd_pkg::FlagW-1:0] flags_q, flags_d;

  logic                   busy;
  logic                   in_acc;
  logic                   take;
  logic                   at_end;
  logic                   start;
  sbusfrd_pkg::store_wr_t wr;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = busy;
  assign in_acc      = in_valid_i && !busy;
  // while hunting, everything but the start byte is dropped
  assign take        = in_acc && (in_frame_q || (rx_byte_i == start_byte_q));
  assign at_end      = (pos_q == sbusfrd_pkg::EndPos);
  assign start       = take && at_end && (rx_byte_i == end_byte_q);

  assign wr.we   = take;
  assign wr.addr = pos_q;
  assign wr.data = rx_byte_i;

  always_comb begin
    start_byte_d = start_byte_q;
    end_byte_d   = end_byte_q;
    if (cfg_valid_i) begin
      case (cfg_index_i)
        sbusfrd_pkg::RegStartByte: start_byte_d = cfg_data_i;
        sbusfrd_pkg::RegEndByte:   end_byte_d   = cfg_data_i;
        default:                   start_byte_d = start_byte_q;
      endcase
    end
  end

  always_comb begin
    in_frame_d = in_frame_q;
    pos_d      = pos_q;
    flags_d    = flags_q;
    if (take) begin
      if (at_end) begin
        in_frame_d = 1'b0;
        pos_d      = '0;
      end else begin
        in_frame_d = 1'b1;
        pos_d      = pos_q + 1'b1;
      end
      if (pos_q == sbusfrd_pkg::FlagsPos) begin
        flags_d = rx_byte_i[sbusfrd_pkg::FlagW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_byte_q <= sbusfrd_pkg::StartByteRst;
      end_byte_q   <= sbusfrd_pkg::EndByteRst;
      in_frame_q   <= 1'b0;
      pos_q        <= '0;
    end else begin
      start_byte_q <= start_byte_d;
      end_byte_q   <= end_byte_d;
      in_frame_q   <= in_frame_d;
      pos_q        <= pos_d;
    end
  end

  always_ff @(posedge clk_i) begin
    flags_q <= flags_d;
  end

  sbusfrd_unpack u_unpack (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .wr_i            (wr),
    .start_i         (start),
    .flags_i         (flags_q),
    .busy_o          (busy),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .channel_index_o (channel_index_o),
    .channel_value_o (channel_value_o),
    .digital_a_o     (digital_a_o),
    .digital_b_o     (digital_b_o),
    .frame_lost_o    (frame_lost_o),
    .failsafe_o      (failsafe_o),
    .last_o          (last_o)
  );

endmodule

[rtl/core/sbusfrd_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sbusfrd_checker: port-level checks for the frame decoder
// Watches the top-level ports and flags handshake or sequencing slips.
// ---------------------------------------------------------------------------
module sbusfrd_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_stall_o,
  input logic                            out_valid_o,
  input logic                            out_stall_i,
  input logic [sbusfrd_pkg::IdxW-1:0]    channel_index_o,
  input logic [sbusfrd_pkg::ChanW-1:0]   channel_value_o,
  input logic                            last_o
);

  // a stalled item stays offered
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("out item dropped while stalled");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(channel_value_o) && $stable(channel_index_o))
    else $error("out payload changed while stalled");

  // last mark only on the sixteenth channel
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (last_o == (channel_index_o == sbusfrd_pkg::LastChan)))
    else $error("last mark does not match channel index");

  // input is held off until the whole frame has been unpacked
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_o |-> in_stall_o)
    else $error("input taken while a frame is still unpacking");

endmodule

bind sbus_frame_receiver_decoder_top sbusfrd_checker u_sbusfrd_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .in_stall_o      (in_stall_o),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .channel_index_o (channel_index_o),
  .channel_value_o (channel_value_o),
  .last_o          (last_o)
);
